// ----- hdl/pmf_pkg.sv -----
// pmf_pkg: shared types and constants for the pedal level median filter
// no dependencies; imported by the core, the median unit and the checker
package pmf_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 23;
  localparam int LEVEL_W    = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 23;
  localparam int COUNT_W    = 8;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int GAIN_FRAC  = 16;

  // defaults and fixed constants
  localparam int WINDOW_SIZE_DEF = 32;
  localparam logic [COUNT_W-1:0] REPORT_INTERVAL = 8'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 23'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE = 8'd3;

  typedef logic [LEVEL_W-1:0] level_t;

  // request from the core to the median unit
  typedef struct packed {
    logic   load;   // write level into the ring and start a window scan
    level_t level;
  } med_req_t;

  // status from the median unit back to the core
  typedef struct packed {
    logic   done;   // one-cycle pulse, median valid from then on
    level_t median;
  } med_stat_t;

endpackage

// ----- hdl/pmf_median.sv -----
// pmf_median: level ring and window median search, one candidate per cycle
// depends on pmf_pkg; a shared comparator bank plus a registered count tree
module pmf_median #(
  parameter int WINDOW_SIZE = pmf_pkg::WINDOW_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pmf_pkg::med_req_t  req,
  output pmf_pkg::med_stat_t stat
);
  import pmf_pkg::*;

  localparam int IW   = $clog2(WINDOW_SIZE);
  localparam int HALF = WINDOW_SIZE / 2;
  localparam int CW   = $clog2(WINDOW_SIZE + 1);
  localparam int NG   = (WINDOW_SIZE + 7) / 8;
  localparam int GW   = 4;
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_SIZE - 1);

  // ring and write pointer
  level_t        win [WINDOW_SIZE];
  logic [IW-1:0] widx;

  // scan control
  logic          issuing;
  logic          running;
  logic [IW-1:0] issue_idx;
  logic          done;
  level_t        median;

  // stage 1: compare vectors of one candidate
  logic              s1_valid;
  logic              s1_last;
  level_t            s1_cand;
  logic [NG*8-1:0]   s1_lt;
  logic [NG*8-1:0]   s1_gt;

  // stage 2: per-group counts
  logic              s2_valid;
  logic              s2_last;
  level_t            s2_cand;
  logic [GW-1:0]     s2_lt_grp [NG];
  logic [GW-1:0]     s2_gt_grp [NG];

  // combinational parts of each stage
  level_t            cand;
  logic [NG*8-1:0]   lt_vec;
  logic [NG*8-1:0]   gt_vec;
  logic [GW-1:0]     lt_grp [NG];
  logic [GW-1:0]     gt_grp [NG];
  logic [CW-1:0]     lt_sum;
  logic [CW-1:0]     gt_sum;
  logic              cand_ok;
  logic              finish;

  // compare the current candidate against every ring entry
  always_comb begin
    cand   = win[issue_idx];
    lt_vec = '0;
    gt_vec = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      lt_vec[j] = (win[j] < cand);
      gt_vec[j] = (win[j] > cand);
    end
  end

  // count set bits in groups of eight
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      lt_grp[g] = '0;
      gt_grp[g] = '0;
      for (int k = 0; k < 8; k++) begin
        lt_grp[g] = lt_grp[g] + GW'(s1_lt[g*8+k]);
        gt_grp[g] = gt_grp[g] + GW'(s1_gt[g*8+k]);
      end
    end
  end

  // add group counts and test the median condition
  always_comb begin
    lt_sum = '0;
    gt_sum = '0;
    for (int g = 0; g < NG; g++) begin
      lt_sum = lt_sum + CW'(s2_lt_grp[g]);
      gt_sum = gt_sum + CW'(s2_gt_grp[g]);
    end
    cand_ok = (lt_sum <= CW'(HALF)) && (gt_sum <= CW'(HALF));
    finish  = running && s2_valid && (cand_ok || s2_last);
  end

  // ring writes and scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        win[j] <= '0;
      end
      widx      <= '0;
      issue_idx <= '0;
      issuing   <= 1'b0;
      running   <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      done      <= 1'b0;
      median    <= '0;
    end else begin
      done <= 1'b0;
      if (req.load) begin
        win[widx] <= req.level;
        widx      <= (widx == LAST_IDX) ? '0 : widx + 1'b1;
        issue_idx <= '0;
        issuing   <= 1'b1;
        running   <= 1'b1;
        s1_valid  <= 1'b0;
        s2_valid  <= 1'b0;
      end else if (running) begin
        s1_valid <= issuing;
        s2_valid <= s1_valid;
        if (issuing) begin
          if (issue_idx == LAST_IDX) begin
            issuing <= 1'b0;
          end else begin
            issue_idx <= issue_idx + 1'b1;
          end
        end
        // first candidate in index order wins; no candidate gives zero
        if (finish) begin
          median   <= cand_ok ? s2_cand : '0;
          done     <= 1'b1;
          running  <= 1'b0;
          issuing  <= 1'b0;
          s1_valid <= 1'b0;
          s2_valid <= 1'b0;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_cand <= cand;
    s1_lt   <= lt_vec;
    s1_gt   <= gt_vec;
    s1_last <= (issue_idx == LAST_IDX);
    s2_cand <= s1_cand;
    s2_last <= s1_last;
    for (int g = 0; g < NG; g++) begin
      s2_lt_grp[g] <= lt_grp[g];
      s2_gt_grp[g] <= gt_grp[g];
    end
  end

  assign stat.done   = done;
  assign stat.median = median;

endmodule

// ----- hdl/pedal_level_median_filter_core.sv -----
// A result shows on m_tvalid after the input transfer once the window scan, one
// candidate a cycle through a three-stage compare and count pipeline, has ended.
// One sample is taken at a time: s_tready returns together with m_tvalid, and the
// output register holds the result while the next sample is taken.
// Reset (rst, synchronous): registers to defaults, ring and history zero.
module pedal_level_median_filter_core #(
  parameter int WINDOW_SIZE = pmf_pkg::WINDOW_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [11:0] sample
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [6:0] filtered_level
  output logic                              m_tuser,   // [0] report
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pmf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_LEVEL  = 5'b00100,
    ST_MEDIAN = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [SAMPLE_W-1:0] cal_low;
  logic [GAIN_W-1:0]   gain_q16;
  logic                invert;
  logic                report_enable;

  // datapath
  logic [SAMPLE_W-1:0] sample_in;
  logic [SAMPLE_W-1:0] diff;
  logic [PROD_W-1:0]   prod;
  level_t              level_sat;
  level_t              level;

  // report history
  level_t              last_report;
  level_t              earlier_report;
  logic [COUNT_W-1:0]  change_count;
  logic                qualify;
  logic                fire;

  med_req_t            med_req;
  med_stat_t           med_stat;

  logic                in_xfer;
  logic                out_free;

  assign sample_in = s_tdata[SAMPLE_W-1:0];
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_low       <= '0;
      gain_q16      <= GAIN_RESET;
      invert        <= 1'b0;
      report_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAL_LOW:       cal_low       <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN_Q16:      gain_q16      <= cfg_data[GAIN_W-1:0];
        REG_INVERT:        invert        <= cfg_data[0];
        REG_REPORT_ENABLE: report_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_xfer) state_next = ST_MUL;
      ST_MUL:    state_next = ST_LEVEL;
      ST_LEVEL:  state_next = ST_MEDIAN;
      ST_MEDIAN: if (med_stat.done) state_next = ST_EMIT;
      ST_EMIT:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // offset removal at transfer, then the gain product
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      diff <= (sample_in > cal_low) ? sample_in - cal_low : '0;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(diff) * PROD_W'(gain_q16);
    end
  end

  // drop the fraction, saturate and mirror
  always_comb begin
    level_sat = (|prod[PROD_W-1:GAIN_FRAC+LEVEL_W]) ? LEVEL_MAX
                                                    : prod[GAIN_FRAC+LEVEL_W-1:GAIN_FRAC];
    level     = invert ? LEVEL_MAX - level_sat : level_sat;
  end

  assign med_req.load  = (state == ST_LEVEL);
  assign med_req.level = level;

  pmf_median #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_median (
    .clk  (clk),
    .rst  (rst),
    .req  (med_req),
    .stat (med_stat)
  );

  // change report decision
  assign qualify = report_enable && (med_stat.median != last_report)
                   && (med_stat.median != earlier_report);
  assign fire    = qualify && (change_count == REPORT_INTERVAL);

  // report history and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_report    <= '0;
      earlier_report <= '0;
      change_count   <= '0;
      m_tvalid       <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
      if (fire) begin
        change_count   <= '0;
        earlier_report <= last_report;
        last_report    <= med_stat.median;
      end else if (qualify) begin
        change_count <= change_count + 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= {1'b0, med_stat.median};
      m_tuser <= fire;
    end
  end

endmodule

// ----- hdl/pmf_checker.sv -----
// pmf_checker: port-level assertions for the pedal level median filter core
// depends on pmf_pkg; bound to pedal_level_median_filter_core below
module pmf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);
  import pmf_pkg::*;

  // a sample transfer keeps the input closed through the scaling steps
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("input reopened too early after a transfer");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // the level never exceeds its seven bits
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:LEVEL_W] == '0))
    else $error("output level out of range");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind pedal_level_median_filter_core pmf_checker u_pmf_checker (.*);
